FILE: rtl/rbid_pkg.sv
// Shared types and constants for the rotating beacon identifier block.
// Holds the SHA-256 round constants, initial hash words and the control command type.
// No dependencies.
package rbid_pkg;

   // Round count and round index width
   localparam int ROUNDS  = 64;
   localparam int ROUND_W = $clog2(ROUNDS);

   // Schedule window and hash state sizes
   localparam int SCHED_WORDS = 16;
   localparam int STATE_WORDS = 8;

   // Message length in bits (14 bytes), stored in the last block word
   localparam logic [31:0] MSG_BITS = 32'd112;

   // Padding marker that follows the last message byte
   localparam logic [15:0] PAD_MARK = 16'h8000;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAJOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY   = 2'd2;

   localparam int MAJOR_W = 16;
   localparam int MINOR_W = 16;
   localparam int KEY_W   = 48;
   localparam int CSR_DATA_W = KEY_W;

   localparam logic [31:0] K_ROUNDS [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] H_INIT [STATE_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Commands from the controller to the datapath
   typedef struct packed {
      logic               load;       // capture request and start a new block
      logic               round_en;   // run one compression round
      logic               fold_load;  // fold digest into the result register
      logic [ROUND_W-1:0] round;      // current round index
   } rbid_cmd_type;

endpackage

FILE: rtl/rbid_ctrl.sv
// Controller for the rotating beacon identifier block.
// Sequences load, 64 compression rounds and the digest fold; owns the result valid.
// Depends on rbid_pkg.
module rbid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rbid_pkg::rbid_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FOLD
   } state_type;

   localparam logic [rbid_pkg::ROUND_W-1:0] LAST_ROUND =
      rbid_pkg::ROUND_W'(rbid_pkg::ROUNDS - 1);

   state_type                     state_ff, state_in;
   logic [rbid_pkg::ROUND_W-1:0]  round_ff, round_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          out_free;

   // Result register can take a new value when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd.load      = 1'b0;
      cmd.round_en  = 1'b0;
      cmd.fold_load = 1'b0;
      cmd.round     = round_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               round_in = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (out_free) begin
               cmd.fold_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   // A new result only appears out of the fold step
   a_valid_from_fold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FOLD))
      else $error("result valid rose outside the fold step");

   // An accepted request starts the rounds at round zero
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_RUN && round_ff == '0))
      else $error("accepted request did not start the rounds");

   // The last round always hands over to the fold step
   a_last_round_folds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && round_ff == LAST_ROUND) |=> (state_ff == ST_FOLD))
      else $error("last round did not move to fold");

   // A pending result is never overwritten while stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.fold_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("fold loaded over a stalled result");
`endif

endmodule

FILE: rtl/rbid_dp.sv
// Datapath for the rotating beacon identifier block.
// Holds the message schedule window, the SHA-256 working words and the result register.
// Depends on rbid_pkg.
module rbid_dp (
   input  logic                          clock,
   input  rbid_pkg::rbid_cmd_type        cmd,
   input  logic [rbid_pkg::MAJOR_W-1:0]  beacon_major,
   input  logic [rbid_pkg::MINOR_W-1:0]  beacon_minor,
   input  logic [rbid_pkg::KEY_W-1:0]    secret_key,
   input  logic [31:0]                   timestamp,
   output logic [31:0]                   rotating_id
);

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   logic [31:0] w_ff [rbid_pkg::SCHED_WORDS];
   logic [31:0] w_in [rbid_pkg::SCHED_WORDS];
   logic [31:0] s_ff [rbid_pkg::STATE_WORDS];
   logic [31:0] s_in [rbid_pkg::STATE_WORDS];
   logic [31:0] rot_id_ff, rot_id_in;
   logic [31:0] w_next;
   logic [31:0] t1, t2;
   logic [31:0] ch_val, maj_val;

   // Next schedule word from the sliding window
   assign w_next = w_ff[0] + small_sigma0(w_ff[1]) + w_ff[9] + small_sigma1(w_ff[14]);

   // Round functions
   assign ch_val  = (s_ff[4] & s_ff[5]) ^ (~s_ff[4] & s_ff[6]);
   assign maj_val = (s_ff[0] & s_ff[1]) ^ (s_ff[0] & s_ff[2]) ^ (s_ff[1] & s_ff[2]);
   assign t1 = s_ff[7] + big_sigma1(s_ff[4]) + ch_val
             + rbid_pkg::K_ROUNDS[cmd.round] + w_ff[0];
   assign t2 = big_sigma0(s_ff[0]) + maj_val;

   // Load the padded block or advance the schedule window
   always_comb begin
      for (int i = 0; i < rbid_pkg::SCHED_WORDS; i++) begin
         w_in[i] = w_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < rbid_pkg::SCHED_WORDS; i++) begin
            w_in[i] = '0;
         end
         w_in[0]  = {beacon_major, beacon_minor};
         w_in[1]  = secret_key[47:16];
         w_in[2]  = {secret_key[15:0], timestamp[31:16]};
         w_in[3]  = {timestamp[15:0], rbid_pkg::PAD_MARK};
         w_in[15] = rbid_pkg::MSG_BITS;
      end else if (cmd.round_en) begin
         for (int i = 0; i < rbid_pkg::SCHED_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[rbid_pkg::SCHED_WORDS - 1] = w_next;
      end
   end

   // Initialize or rotate the working words
   always_comb begin
      for (int i = 0; i < rbid_pkg::STATE_WORDS; i++) begin
         s_in[i] = s_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < rbid_pkg::STATE_WORDS; i++) begin
            s_in[i] = rbid_pkg::H_INIT[i];
         end
      end else if (cmd.round_en) begin
         s_in[7] = s_ff[6];
         s_in[6] = s_ff[5];
         s_in[5] = s_ff[4];
         s_in[4] = s_ff[3] + t1;
         s_in[3] = s_ff[2];
         s_in[2] = s_ff[1];
         s_in[1] = s_ff[0];
         s_in[0] = t1 + t2;
      end
   end

   // Fold the final digest words by XOR
   always_comb begin
      rot_id_in = '0;
      for (int i = 0; i < rbid_pkg::STATE_WORDS; i++) begin
         rot_id_in = rot_id_in ^ (rbid_pkg::H_INIT[i] + s_ff[i]);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < rbid_pkg::SCHED_WORDS; i++) begin
         w_ff[i] <= w_in[i];
      end
      for (int i = 0; i < rbid_pkg::STATE_WORDS; i++) begin
         s_ff[i] <= s_in[i];
      end
      if (cmd.fold_load) begin
         rot_id_ff <= rot_id_in;
      end
   end

   assign rotating_id = rot_id_ff;

endmodule

FILE: rtl/rotating_beacon_id_sha256_fold.sv
// Rotating beacon identifier: SHA-256 over major, minor, key and timestamp, XOR-folded to 32 bits.
// A result is loaded once the rounds are done and the fold step finds the result register free.
// The single shared round unit takes a new request only after the previous one has been folded.
// The result register is separate, so the next request is taken while a result waits.
// Reset (synchronous): controller idle, no result pending, configuration registers cleared.
// Depends on rbid_pkg, rbid_ctrl and rbid_dp.
module rotating_beacon_id_sha256_fold (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [31:0]                         req_timestamp,
   // Result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_rotating_id,
   // Configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbid_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbid_pkg::CSR_DATA_W-1:0]     csr_data
);

   rbid_pkg::rbid_cmd_type              cmd;
   logic [rbid_pkg::MAJOR_W-1:0]        major_ff, major_in;
   logic [rbid_pkg::MINOR_W-1:0]        minor_ff, minor_in;
   logic [rbid_pkg::KEY_W-1:0]          key_ff, key_in;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   // Decode register writes; unknown indexes drop the write
   always_comb begin
      major_in = major_ff;
      minor_in = minor_ff;
      key_in   = key_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rbid_pkg::CSR_MAJOR: major_in = csr_data[rbid_pkg::MAJOR_W-1:0];
            rbid_pkg::CSR_MINOR: minor_in = csr_data[rbid_pkg::MINOR_W-1:0];
            rbid_pkg::CSR_KEY:   key_in   = csr_data[rbid_pkg::KEY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff <= '0;
         minor_ff <= '0;
         key_ff   <= '0;
      end else begin
         major_ff <= major_in;
         minor_ff <= minor_in;
         key_ff   <= key_in;
      end
   end

   rbid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rbid_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .beacon_major (major_ff),
      .beacon_minor (minor_ff),
      .secret_key   (key_ff),
      .timestamp    (req_timestamp),
      .rotating_id  (rsp_rotating_id)
   );

endmodule
